// File: sv/assert_macros.svh
// Assertion helpers shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at each rising edge, skipped while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");

// Check a property at each rising edge, reset included.
`define ASSERT_ALWAYS_CLK(label, clk, prop) \
	label: assert property (@(posedge clk) prop) \
		else $error("assertion failed");

`endif

// File: sv/u8v_pkg.sv
// ----------------------------------------------------------------------------
// u8v_pkg
// Types, codes and helpers of the single-line UTF-8 validator.
// ----------------------------------------------------------------------------
package u8v_pkg;

	typedef enum logic [1:0] {
		ST_VALID    = 2'd0,
		ST_BAD_UTF8 = 2'd1,
		ST_CONTROL  = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		CLS_ASCII_OK,
		CLS_ASCII_CTRL,
		CLS_LEAD2,
		CLS_LEAD3,
		CLS_LEAD4,
		CLS_BAD
	} byte_cls_t;

	// One classified word passed from front to back.
	typedef struct packed {
		logic [7:0] data;
		logic       last;
		byte_cls_t  cls;
		logic       cont;   // 0x80..0xBF
		logic       ge_a0;
		logic       le_9f;
		logic       ge_90;
		logic       le_8f;
	} u8v_item_t;

	localparam logic [7:0] LEAD_E0 = 8'he0;
	localparam logic [7:0] LEAD_ED = 8'hed;
	localparam logic [7:0] LEAD_F0 = 8'hf0;
	localparam logic [7:0] LEAD_F4 = 8'hf4;

	localparam logic [20:0] CP_TAB     = 21'h09;
	localparam logic [20:0] CP_C0_LAST = 21'h1f;
	localparam logic [20:0] CP_DEL     = 21'h7f;
	localparam logic [20:0] CP_C1_LAST = 21'h9f;
	localparam logic [20:0] CP_LSEP    = 21'h2028;
	localparam logic [20:0] CP_PSEP    = 21'h2029;

	function automatic logic line_ok(input logic [20:0] cp);
		line_ok = (cp == CP_TAB || cp > CP_C0_LAST) &&
			!(cp >= CP_DEL && cp <= CP_C1_LAST) &&
			cp != CP_LSEP && cp != CP_PSEP;
	endfunction

endpackage

// File: sv/u8v_fifo.sv
// ----------------------------------------------------------------------------
// u8v_fifo
// Small register queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module u8v_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = cnt_q == CW'(DEPTH);
	assign empty   = cnt_q == '0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// File: sv/u8v_front.sv
// ----------------------------------------------------------------------------
// u8v_front
// Accepts text bytes, classifies each and tags it with its byte offset.
// ----------------------------------------------------------------------------
module u8v_front import u8v_pkg::*; #(
	parameter int OFFSET_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	output logic                   full,
	input  logic [7:0]             text_byte,
	input  logic                   final_byte,
	output logic                   q_push,
	output u8v_item_t              q_item,
	output logic [OFFSET_BITS-1:0] q_pos,
	input  logic                   q_full
);
	logic [OFFSET_BITS-1:0] pos_q;
	logic                   accept;

	assign full   = q_full;
	assign accept = push && !q_full;
	assign q_push = accept;
	assign q_pos  = pos_q;

	always_comb begin
		q_item.data  = text_byte;
		q_item.last  = final_byte;
		q_item.cont  = text_byte[7:6] == 2'b10;
		q_item.ge_a0 = text_byte >= 8'ha0;
		q_item.le_9f = text_byte <= 8'h9f;
		q_item.ge_90 = text_byte >= 8'h90;
		q_item.le_8f = text_byte <= 8'h8f;
		case (text_byte) inside
			[8'h00:8'h7f]: q_item.cls = line_ok({13'b0, text_byte}) ?
				CLS_ASCII_OK : CLS_ASCII_CTRL;
			[8'hc2:8'hdf]: q_item.cls = CLS_LEAD2;
			[8'he0:8'hef]: q_item.cls = CLS_LEAD3;
			[8'hf0:8'hf4]: q_item.cls = CLS_LEAD4;
			default:       q_item.cls = CLS_BAD;
		endcase
	end

	// Offset saturates; a final byte starts the next text at zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (accept) begin
			if (final_byte) begin
				pos_q <= '0;
			end else if (pos_q != '1) begin
				pos_q <= pos_q + 1'b1;
			end
		end
	end

endmodule

// File: sv/u8v_back.sv
// ----------------------------------------------------------------------------
// u8v_back
// Runs the UTF-8 sequence checker on classified words and emits the result.
// ----------------------------------------------------------------------------
module u8v_back import u8v_pkg::*; #(
	parameter int OFFSET_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  u8v_item_t              in_item,
	input  logic [OFFSET_BITS-1:0] in_pos,
	output logic                   in_pop,
	output logic                   res_push,
	output status_t                res_status,
	output logic [OFFSET_BITS-1:0] res_offset,
	input  logic                   res_full
);
	logic [1:0]             rem_q,   rem_n;
	logic [7:0]             lead_q,  lead_n;
	logic [20:0]            acc_q,   acc_n;
	logic [OFFSET_BITS-1:0] start_q, start_n;
	status_t                stat_q,  stat_n;
	logic [OFFSET_BITS-1:0] off_q,   off_n;
	logic                   fire;
	logic                   second;
	logic                   cont_ok;

	// Stall only a final word that finds the result queue full.
	assign fire     = in_valid && (!in_item.last || !res_full);
	assign in_pop   = fire;
	assign res_push = fire && in_item.last;

	always_comb begin
		if (lead_q >= LEAD_F0) begin
			second = rem_q == 2'd3;
		end else if (lead_q >= LEAD_E0) begin
			second = rem_q == 2'd2;
		end else begin
			second = rem_q == 2'd1;
		end
		cont_ok = in_item.cont;
		if (second) begin
			case (lead_q)
				LEAD_E0: cont_ok = in_item.cont && in_item.ge_a0;
				LEAD_ED: cont_ok = in_item.cont && in_item.le_9f;
				LEAD_F0: cont_ok = in_item.cont && in_item.ge_90;
				LEAD_F4: cont_ok = in_item.cont && in_item.le_8f;
				default: cont_ok = in_item.cont;
			endcase
		end
	end

	always_comb begin
		rem_n   = rem_q;
		lead_n  = lead_q;
		acc_n   = acc_q;
		start_n = start_q;
		stat_n  = stat_q;
		off_n   = off_q;
		if (stat_q == ST_VALID) begin
			if (rem_q == 2'd0) begin
				start_n = in_pos;
				lead_n  = in_item.data;
				case (in_item.cls)
					CLS_ASCII_OK: ;
					CLS_ASCII_CTRL: begin
						stat_n = ST_CONTROL;
						off_n  = in_pos;
					end
					CLS_LEAD2: begin
						rem_n = 2'd1;
						acc_n = {16'b0, in_item.data[4:0]};
					end
					CLS_LEAD3: begin
						rem_n = 2'd2;
						acc_n = {17'b0, in_item.data[3:0]};
					end
					CLS_LEAD4: begin
						rem_n = 2'd3;
						acc_n = {18'b0, in_item.data[2:0]};
					end
					default: begin
						stat_n = ST_BAD_UTF8;
						off_n  = in_pos;
					end
				endcase
			end else if (!cont_ok) begin
				rem_n  = 2'd0;
				stat_n = ST_BAD_UTF8;
				off_n  = start_q;
			end else begin
				acc_n = {acc_q[14:0], in_item.data[5:0]};
				rem_n = rem_q - 2'd1;
				if (rem_n == 2'd0 && !line_ok(acc_n)) begin
					stat_n = ST_CONTROL;
					off_n  = start_q;
				end
			end
		end
	end

	// Text cut short: invalid at the open sequence's lead byte.
	always_comb begin
		res_status = stat_n;
		res_offset = off_n;
		if (stat_n == ST_VALID && rem_n != 2'd0) begin
			res_status = ST_BAD_UTF8;
			res_offset = start_n;
		end
		if (res_status == ST_VALID) begin
			res_offset = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q   <= '0;
			lead_q  <= '0;
			acc_q   <= '0;
			start_q <= '0;
			stat_q  <= ST_VALID;
			off_q   <= '0;
		end else if (fire) begin
			if (in_item.last) begin
				rem_q   <= '0;
				lead_q  <= '0;
				acc_q   <= '0;
				start_q <= '0;
				stat_q  <= ST_VALID;
				off_q   <= '0;
			end else begin
				rem_q   <= rem_n;
				lead_q  <= lead_n;
				acc_q   <= acc_n;
				start_q <= start_n;
				stat_q  <= stat_n;
				off_q   <= off_n;
			end
		end
	end

endmodule

// File: sv/utf8_single_line_validator.sv
// ----------------------------------------------------------------------------
// utf8_single_line_validator
// Strict UTF-8 single-line text checker, one byte word per clock unless full.
//
//   channel  | handshake    | words
//   ---------+--------------+--------------------------------
//   input    | push / full  | text_byte, final_byte
//   result   | pop / empty  | status, error_offset
//
// One byte word is taken every cycle while full is low; a word is registered
// in the front queue before the sequence checker consumes it, and its verdict
// is registered in the result queue before it reaches the result ports.
// The checker takes one word per cycle into its state registers unless stalled.
// Reset clears all state and both queues.
// Input stalls only when the front queue fills, which happens when a final
// word meets a full result queue.
// ----------------------------------------------------------------------------
module utf8_single_line_validator import u8v_pkg::*; #(
	parameter int OFFSET_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  text_byte,
	input  logic        final_byte,
	output logic        empty,
	input  logic        pop,
	output logic [1:0]  status,
	output logic [15:0] error_offset
);
	localparam int ITEM_W = $bits(u8v_item_t);
	localparam int MID_W  = ITEM_W + OFFSET_BITS;
	localparam int RES_W  = 2 + OFFSET_BITS;

	logic                   f_push;
	u8v_item_t              f_item;
	logic [OFFSET_BITS-1:0] f_pos;
	logic                   mid_full;
	logic                   mid_empty;
	logic [MID_W-1:0]       mid_rdata;
	u8v_item_t              b_item;
	logic [OFFSET_BITS-1:0] b_pos;
	logic                   b_pop;
	logic                   r_push;
	status_t                r_status;
	logic [OFFSET_BITS-1:0] r_offset;
	logic                   r_full;
	logic [RES_W-1:0]       r_rdata;
	logic [OFFSET_BITS+15:0] off_ext;

	u8v_front #(.OFFSET_BITS(OFFSET_BITS)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.text_byte  (text_byte),
		.final_byte (final_byte),
		.q_push     (f_push),
		.q_item     (f_item),
		.q_pos      (f_pos),
		.q_full     (mid_full)
	);

	u8v_fifo #(.WIDTH(MID_W), .DEPTH(2)) u_mid_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (f_push),
		.wdata  ({f_pos, f_item}),
		.full   (mid_full),
		.pop    (b_pop),
		.rdata  (mid_rdata),
		.empty  (mid_empty)
	);

	assign b_item = u8v_item_t'(mid_rdata[ITEM_W-1:0]);
	assign b_pos  = mid_rdata[MID_W-1:ITEM_W];

	u8v_back #(.OFFSET_BITS(OFFSET_BITS)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (!mid_empty),
		.in_item    (b_item),
		.in_pos     (b_pos),
		.in_pop     (b_pop),
		.res_push   (r_push),
		.res_status (r_status),
		.res_offset (r_offset),
		.res_full   (r_full)
	);

	u8v_fifo #(.WIDTH(RES_W), .DEPTH(2)) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (r_push),
		.wdata  ({r_status, r_offset}),
		.full   (r_full),
		.pop    (pop),
		.rdata  (r_rdata),
		.empty  (empty)
	);

	assign status       = r_rdata[RES_W-1:OFFSET_BITS];
	assign off_ext      = {16'b0, r_rdata[OFFSET_BITS-1:0]};
	assign error_offset = off_ext[15:0];

endmodule

// File: sv/u8v_checker.sv
// ----------------------------------------------------------------------------
// u8v_checker
// Port-level checks of the validator's result queue.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module u8v_checker import u8v_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        empty,
	input logic        pop,
	input logic [1:0]  status,
	input logic [15:0] error_offset
);

	`ASSERT_CLK(a_status_legal, clk, arst_n, !empty |-> (status == ST_VALID || status == ST_BAD_UTF8 || status == ST_CONTROL))
	`ASSERT_CLK(a_valid_zero_off, clk, arst_n, (!empty && status == ST_VALID) |-> error_offset == 16'd0)
	`ASSERT_CLK(a_hold_stalled, clk, arst_n, (!empty && !pop) |=> (!empty && $stable(status) && $stable(error_offset)))
	`ASSERT_ALWAYS_CLK(a_empty_in_reset, clk, !arst_n |-> empty)

endmodule

bind utf8_single_line_validator u8v_checker u_u8v_checker (.*);

// File: bench/utf8_single_line_validator_test.sv
// ----------------------------------------------------------------------------
// utf8_single_line_validator_test
// Self-checking bench for the single-line UTF-8 validator. A driver pushes
// byte words from a pending queue and scores each accepted word against
// its own model of the sequence checker. A monitor pops verdicts and
// compares them with the oldest predicted one. Both sides idle in random
// bursts. Stimulus covers directed corner cases, random texts of mixed
// well-formed and broken sequences, and one longer text with a control
// byte near its end.
// ----------------------------------------------------------------------------
module utf8_single_line_validator_test;
	import u8v_pkg::*;

	localparam int RANDOM_BYTES    = 520;
	localparam int LONG_TEXT_BYTES = 100;
	localparam int TAIL_BYTES      = 120;
	localparam int STALL_LIMIT     = 1000;
	localparam int MAX_REPORTS     = 30;

	typedef struct {
		bit [7:0] b;
		bit       last;
		bit       drain;   // hold this word until every verdict has come back
	} pending_word_t;

	typedef struct {
		status_t   st;
		bit [15:0] off;
	} verdict_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b1;
	logic        push = 1'b0;
	logic        full;
	logic [7:0]  text_byte = '0;
	logic        final_byte = 1'b0;
	logic        empty;
	logic        pop = 1'b0;
	logic [1:0]  status;
	logic [15:0] error_offset;

	pending_word_t pending_words[$];
	verdict_t      expected_verdicts[$];
	bit [7:0]      text_bytes[$];

	// model of the sequence checker
	bit [1:0]  cont_left;
	bit [7:0]  seq_lead;
	bit [20:0] cp_acc;
	bit [15:0] byte_pos;
	bit [15:0] seq_start;
	status_t   err_status;
	bit [15:0] err_offset;

	int gap_left;
	int stall_left;
	int quiet_cycles;
	int bytes_sent;
	int texts_queued;
	int verdicts_checked;
	int mismatches;
	int calm_after = 32'h7fffffff;

	pending_word_t next_word;
	logic          next_push;
	verdict_t      want;

	utf8_single_line_validator DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.text_byte    (text_byte),
		.final_byte   (final_byte),
		.empty        (empty),
		.pop          (pop),
		.status       (status),
		.error_offset (error_offset)
	);

	always #5 clk = ~clk;

	function automatic bit line_safe(input bit [20:0] cp);
		return (cp == CP_TAB || cp > CP_C0_LAST) && !(cp >= CP_DEL && cp <= CP_C1_LAST) &&
			cp != CP_LSEP && cp != CP_PSEP;
	endfunction

	function automatic bit quiet_tail();
		return bytes_sent >= calm_after;
	endfunction

	task automatic clear_text_state();
		cont_left  = '0;
		seq_lead   = '0;
		cp_acc     = '0;
		byte_pos   = '0;
		seq_start  = '0;
		err_status = ST_VALID;
		err_offset = '0;
	endtask

	task automatic note_error(input status_t s, input bit [15:0] at);
		err_status = s;
		err_offset = at;
	endtask

	// Advance the model by one byte; on the final byte queue the verdict.
	task automatic absorb_byte(input bit [7:0] b, input bit last);
		bit [7:0] lo;
		bit [7:0] hi;
		bit       second;
		verdict_t v;
		if (err_status == ST_VALID) begin
			if (cont_left == 0) begin
				seq_start = byte_pos;
				seq_lead  = b;
				if (b <= 8'h7f) begin
					if (!line_safe({13'd0, b}))
						note_error(ST_CONTROL, byte_pos);
				end else if (b >= 8'hc2 && b <= 8'hdf) begin
					cont_left = 2'd1;
					cp_acc    = {16'd0, b[4:0]};
				end else if (b >= LEAD_E0 && b <= 8'hef) begin
					cont_left = 2'd2;
					cp_acc    = {17'd0, b[3:0]};
				end else if (b >= LEAD_F0 && b <= LEAD_F4) begin
					cont_left = 2'd3;
					cp_acc    = {18'd0, b[2:0]};
				end else begin
					note_error(ST_BAD_UTF8, byte_pos);
				end
			end else begin
				lo = 8'h80;
				hi = 8'hbf;
				if (seq_lead >= LEAD_F0)
					second = cont_left == 2'd3;
				else if (seq_lead >= LEAD_E0)
					second = cont_left == 2'd2;
				else
					second = cont_left == 2'd1;
				if (second) begin
					case (seq_lead)
						LEAD_E0: lo = 8'ha0;
						LEAD_ED: hi = 8'h9f;
						LEAD_F0: lo = 8'h90;
						LEAD_F4: hi = 8'h8f;
						default: ;
					endcase
				end
				if (b < lo || b > hi) begin
					cont_left = '0;
					note_error(ST_BAD_UTF8, seq_start);
				end else begin
					cp_acc    = {cp_acc[14:0], b[5:0]};
					cont_left = cont_left - 2'd1;
					if (cont_left == 0 && !line_safe(cp_acc))
						note_error(ST_CONTROL, seq_start);
				end
			end
		end
		if (byte_pos != 16'hffff)
			byte_pos = byte_pos + 16'd1;
		if (last) begin
			if (err_status == ST_VALID && cont_left != 0)
				note_error(ST_BAD_UTF8, seq_start);
			v.st  = err_status;
			v.off = (err_status == ST_VALID) ? 16'd0 : err_offset;
			expected_verdicts.push_back(v);
			clear_text_state();
		end
	endtask

	task automatic put_byte(input bit [7:0] b);
		text_bytes.push_back(b);
	endtask

	task automatic put_code_point(input bit [20:0] cp);
		if (cp < 21'h80) begin
			put_byte(cp[7:0]);
		end else if (cp < 21'h800) begin
			put_byte({3'b110, cp[10:6]});
			put_byte({2'b10, cp[5:0]});
		end else if (cp < 21'h10000) begin
			put_byte({4'b1110, cp[15:12]});
			put_byte({2'b10, cp[11:6]});
			put_byte({2'b10, cp[5:0]});
		end else begin
			put_byte({5'b11110, cp[20:18]});
			put_byte({2'b10, cp[17:12]});
			put_byte({2'b10, cp[11:6]});
			put_byte({2'b10, cp[5:0]});
		end
	endtask

	// Move the assembled text into the pending queue, final flag on its last byte.
	task automatic flush_text(input bit drain);
		pending_word_t w;
		for (int i = 0; i < text_bytes.size(); i++) begin
			w.b     = text_bytes[i];
			w.last  = (i == text_bytes.size() - 1);
			w.drain = drain && (i == 0);
			pending_words.push_back(w);
		end
		text_bytes.delete();
		texts_queued++;
	endtask

	task automatic put_random_piece();
		int        kind;
		bit [20:0] cp;
		kind = $urandom_range(0, 99);
		if (kind < 25) begin
			cp = (kind < 2) ? CP_TAB : 21'($urandom_range(32, 126));
			put_code_point(cp);
		end else if (kind < 38) begin
			put_code_point(21'($urandom_range(21'ha0, 21'h7ff)));
		end else if (kind < 52) begin
			cp = 21'($urandom_range(21'h800, 21'hffff));
			if (cp >= 21'hd800 && cp <= 21'hdfff)
				cp = cp + 21'h800;
			if (cp == CP_LSEP || cp == CP_PSEP)
				cp = 21'h2030;
			put_code_point(cp);
		end else if (kind < 64) begin
			put_code_point(21'($urandom_range(21'h10000, 21'h10ffff)));
		end else if (kind < 72) begin
			case ($urandom_range(0, 3))
				0: begin
					cp = 21'($urandom_range(0, 31));
					if (cp == CP_TAB)
						cp = 21'h0a;
				end
				1: cp = CP_DEL;
				2: cp = 21'($urandom_range(21'h80, 21'h9f));
				default: cp = ($urandom_range(0, 1) != 0) ? CP_LSEP : CP_PSEP;
			endcase
			put_code_point(cp);
		end else if (kind < 80) begin
			put_byte(8'($urandom_range(0, 255)));
		end else if (kind < 88) begin
			// valid code points at the edges of the multi-byte encodings and excluded ranges
			case ($urandom_range(0, 7))
				0: cp = 21'ha0;
				1: cp = 21'h7ff;
				2: cp = 21'h800;
				3: cp = 21'hd7ff;
				4: cp = 21'he000;
				5: cp = 21'hffff;
				6: cp = 21'h10000;
				default: cp = 21'h10ffff;
			endcase
			put_code_point(cp);
		end else begin
			case ($urandom_range(0, 5))
				0: begin
					put_byte(8'($urandom_range(8'h80, 8'hc1)));
					put_byte(8'($urandom_range(8'h80, 8'hbf)));
				end
				1: begin
					put_byte(LEAD_E0);
					put_byte(8'($urandom_range(8'h80, 8'h9f)));
					put_byte(8'($urandom_range(8'h80, 8'hbf)));
				end
				2: begin
					put_byte(LEAD_ED);
					put_byte(8'($urandom_range(8'ha0, 8'hbf)));
					put_byte(8'($urandom_range(8'h80, 8'hbf)));
				end
				3: begin
					put_byte(LEAD_F0);
					put_byte(8'($urandom_range(8'h80, 8'h8f)));
					put_byte(8'($urandom_range(8'h80, 8'hbf)));
					put_byte(8'($urandom_range(8'h80, 8'hbf)));
				end
				4: begin
					if ($urandom_range(0, 1) != 0) begin
						put_byte(LEAD_F4);
						put_byte(8'($urandom_range(8'h90, 8'hbf)));
					end else begin
						put_byte(8'($urandom_range(8'hf5, 8'hff)));
					end
					put_byte(8'($urandom_range(8'h80, 8'hbf)));
				end
				default: begin
					// good lead, then a byte that is no continuation
					put_byte(8'($urandom_range(8'hc2, 8'hf4)));
					if ($urandom_range(0, 1) != 0)
						put_byte(8'($urandom_range(0, 8'h7f)));
					else
						put_byte(8'($urandom_range(8'hc0, 8'hff)));
				end
			endcase
		end
	endtask

	task automatic queue_random_texts(input int byte_budget);
		int start;
		int pieces;
		start = pending_words.size();
		while (pending_words.size() - start < byte_budget) begin
			pieces = $urandom_range(1, 6);
			for (int k = 0; k < pieces; k++)
				put_random_piece();
			// cut the text short now and then
			if (text_bytes.size() > 1 && $urandom_range(0, 9) == 0)
				text_bytes.delete(text_bytes.size() - 1);
			flush_text($urandom_range(0, 39) == 0);
		end
	endtask

	// Driver: score the word just accepted, then present the next one.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push       <= 1'b0;
			text_byte  <= '0;
			final_byte <= 1'b0;
			gap_left   = 0;
		end else begin
			if (push && !full) begin
				absorb_byte(text_byte, final_byte);
				bytes_sent++;
				if (!quiet_tail() && $urandom_range(0, 9) == 0)
					gap_left = $urandom_range(1, 17);
			end
			// hold the word while the block is full
			if (!(push && full)) begin
				next_push = 1'b0;
				if (gap_left > 0) begin
					gap_left--;
				end else if (pending_words.size() > 0 &&
					!(pending_words[0].drain && expected_verdicts.size() != 0)) begin
					next_word  = pending_words.pop_front();
					text_byte  <= next_word.b;
					final_byte <= next_word.last;
					next_push  = 1'b1;
				end
				push <= next_push;
			end
		end
	end

	// Monitor: compare each popped verdict with the oldest prediction.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop        <= 1'b0;
			stall_left = 0;
		end else begin
			if (pop && !empty) begin
				if (expected_verdicts.size() == 0) begin
					if (mismatches < MAX_REPORTS)
						$display("%0t: unexpected verdict, expected none, actual status %0d offset %0d",
							$time, status, error_offset);
					mismatches++;
				end else begin
					want = expected_verdicts.pop_front();
					if (status !== want.st) begin
						if (mismatches < MAX_REPORTS)
							$display("%0t: status expected %0d actual %0d",
								$time, want.st, status);
						mismatches++;
					end
					if (error_offset !== want.off) begin
						if (mismatches < MAX_REPORTS)
							$display("%0t: error_offset expected %0d actual %0d",
								$time, want.off, error_offset);
						mismatches++;
					end
					verdicts_checked++;
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
				if (!quiet_tail() && $urandom_range(0, 7) == 0)
					stall_left = $urandom_range(1, 17);
			end
		end
	end

	// Watchdog: end the run when no word moves for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
				$display("[utf8_single_line_validator] ERROR");
				$finish;
			end
		end
	end

	initial begin
		pending_word_t w;
		clear_text_state();
		quiet_cycles = 0;
		#1 arst_n = 1'b0;

		// directed corner cases
		put_byte(8'h09); put_byte(8'h7e); flush_text(1'b0);
		put_byte(8'h00); flush_text(1'b0);
		put_byte(8'h7f); flush_text(1'b0);
		put_byte(8'h41); put_byte(8'hc2); put_byte(8'h80); flush_text(1'b0);
		put_byte(8'he2); put_byte(8'h80); put_byte(8'ha9); flush_text(1'b0);
		put_byte(8'hff); put_byte(8'h00); flush_text(1'b0);
		put_byte(LEAD_E0); put_byte(8'h9f); put_byte(8'hbf); flush_text(1'b0);
		put_byte(LEAD_ED); put_byte(8'ha0); flush_text(1'b0);
		put_byte(LEAD_F4); put_byte(8'h90); flush_text(1'b1);
		put_byte(LEAD_F0); put_byte(8'h9f); put_byte(8'h98); flush_text(1'b0);
		put_byte(LEAD_F4); put_byte(8'h8f); put_byte(8'hbf); put_byte(8'hbf);
		flush_text(1'b0);

		queue_random_texts(RANDOM_BYTES / 2);

		// one longer text with a control byte near its end
		for (int i = 0; i < LONG_TEXT_BYTES; i++) begin
			w.b     = (i == LONG_TEXT_BYTES - 10) ? 8'h01 : 8'h61;
			w.last  = (i == LONG_TEXT_BYTES - 1);
			w.drain = (i == 0);
			pending_words.push_back(w);
		end
		texts_queued++;

		queue_random_texts(RANDOM_BYTES - RANDOM_BYTES / 2);
		calm_after = pending_words.size() - TAIL_BYTES;

		repeat (3) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (pending_words.size() != 0 || push)
			@(negedge clk);
		while (expected_verdicts.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);

		$display("Sent %0d bytes in %0d texts, one of them %0d bytes long.",
			bytes_sent, texts_queued, LONG_TEXT_BYTES);
		$display("Checked %0d verdicts, %0d mismatches.", verdicts_checked, mismatches);
		if (mismatches == 0 && expected_verdicts.size() == 0)
			$display("[utf8_single_line_validator] OK");
		else
			$display("[utf8_single_line_validator] ERROR");
		$finish;
	end

endmodule

// File: filelist.f
+incdir+sv
sv/u8v_pkg.sv
sv/u8v_fifo.sv
sv/u8v_front.sv
sv/u8v_back.sv
sv/utf8_single_line_validator.sv
sv/u8v_checker.sv
bench/utf8_single_line_validator_test.sv
